/* hdl/rational_arith_reduce_defines.svh */
// ============================================================================
// rational_arith_reduce assertion macros
// Concurrent assertion shorthands, clocked on clk and held off during reset.
// ============================================================================
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RAR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RAR_ASSERT_IMPL(label, ante, cons, msg)
`define RAR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hdl/rar_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rar_pkg
// Shared types and constants of the rational arithmetic reducer.
// ============================================================================
package rar_pkg;

    localparam int FIELD_W           = 16;  // width of each operand field
    localparam int RES_NUM_W         = 33;
    localparam int RES_DEN_W         = 32;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL0,
        F_MUL1,
        F_MUL2,
        F_SUM,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GCD,
        B_DIV,
        B_SIGN,
        B_HOLD
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* hdl/rar_ifs.sv */
`timescale 1ns / 1ps
// ============================================================================
// rar channel interfaces
// Valid/ready channels for operand and result transactions.
// ============================================================================
interface rar_in_if import rar_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;

    modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if import rar_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [RES_NUM_W-1:0] res_num;
    logic signed [RES_DEN_W-1:0] res_den;
    logic                        res_valid;

    modport source (output valid, res_num, res_den, res_valid, input ready);
    modport sink   (input valid, res_num, res_den, res_valid, output ready);
endinterface

/* hdl/rational_arith_reduce.sv */
`timescale 1ns / 1ps
// ============================================================================
// rational_arith_reduce
// Signed fraction add/subtract/multiply/divide with gcd reduction.
// ============================================================================
//
//  Channel   Dir  Handshake     Payload
//  --------  ---  ------------  ------------------------------------------
//  operands  in   valid/ready   cmd, a_num, a_den, b_num, b_den
//  result    out  valid/ready   res_num, res_den, res_valid
//
//  Flow: the front takes one transaction at a time, forming the products on
//  one shared multiplier, and is ready for the next only after it pushes
//  the pair; the back reduces each pair by binary gcd and bit-serial exact
//  division, and leaves a pair with both terms zero unreduced.
//  Reset: asynchronous active-low rst_n clears all control state; no pass.
//  Stalls: two-entry queue between front and back; the result register
//  lets the back go on while a finished result waits on result.ready.
//
module rational_arith_reduce import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rar_in_if.sink    operands,
    rar_out_if.source result
);

    localparam int DEN_W = 2 * OPERAND_WIDTH;
    localparam int NUM_W = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;

    q_stat_t                 q_stat;
    logic                    push;
    logic                    pop;
    logic signed [NUM_W-1:0] push_num, head_num;
    logic signed [DEN_W-1:0] push_den, head_den;

    // front: takes transactions, forms raw numerator and denominator
    rar_front #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .q_stat   (q_stat),
        .push     (push),
        .push_num (push_num),
        .push_den (push_den)
    );

    // queue of raw pairs
    rar_queue #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_num (push_num),
        .push_den (push_den),
        .pop      (pop),
        .head_num (head_num),
        .head_den (head_den),
        .q_stat   (q_stat)
    );

    // back: gcd, exact division, result register
    rar_back #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head_num (head_num),
        .head_den (head_den),
        .pop      (pop),
        .result   (result)
    );

endmodule

/* hdl/rar_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// rar_front
// Accepts operand transactions and forms raw cross products on one multiplier.
// ============================================================================
module rar_front import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    localparam int DEN_W = 2 * OPERAND_WIDTH,
    localparam int NUM_W = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    rar_in_if.sink                  operands,
    input  q_stat_t                 q_stat,
    output logic                    push,
    output logic signed [NUM_W-1:0] push_num,
    output logic signed [DEN_W-1:0] push_den
);

    front_state_t state_reg, state_next;

    cmd_t                      cmd_reg;
    logic [FIELD_W-1:0]        an_raw_reg, ad_raw_reg, bn_raw_reg, bd_raw_reg;
    logic signed [DEN_W-1:0]   prod_reg, prod_next;
    logic signed [DEN_W-1:0]   den_reg, den_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;

    logic signed [OPERAND_WIDTH-1:0] an_op, ad_op, bn_op, bd_op;
    logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
    logic                            take;

    // operand fields read as OPERAND_WIDTH-bit two's complement; wider widths zero-extend the field
    if (OPERAND_WIDTH <= FIELD_W) begin : g_narrow
        assign an_op = an_raw_reg[OPERAND_WIDTH-1:0];
        assign ad_op = ad_raw_reg[OPERAND_WIDTH-1:0];
        assign bn_op = bn_raw_reg[OPERAND_WIDTH-1:0];
        assign bd_op = bd_raw_reg[OPERAND_WIDTH-1:0];
    end else begin : g_wide
        assign an_op = {{(OPERAND_WIDTH - FIELD_W){1'b0}}, an_raw_reg};
        assign ad_op = {{(OPERAND_WIDTH - FIELD_W){1'b0}}, ad_raw_reg};
        assign bn_op = {{(OPERAND_WIDTH - FIELD_W){1'b0}}, bn_raw_reg};
        assign bd_op = {{(OPERAND_WIDTH - FIELD_W){1'b0}}, bd_raw_reg};
    end

    assign operands.ready = (state_reg == F_IDLE);
    assign take           = operands.valid && operands.ready;
    assign push_num       = num_reg;
    assign push_den       = den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg    <= cmd_t'(operands.cmd);
            an_raw_reg <= operands.a_num;
            ad_raw_reg <= operands.a_den;
            bn_raw_reg <= operands.b_num;
            bd_raw_reg <= operands.b_den;
        end
        prod_reg <= prod_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
    end

    // schedule: denominator product, first numerator product, second
    // numerator product and their sum or difference (add/subtract only), then the push
    always_comb
    begin
        state_next = state_reg;
        mul_a      = ad_op;
        mul_b      = bd_op;
        den_next   = den_reg;
        num_next   = num_reg;
        push       = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    state_next = F_MUL0;
                end
            end
            F_MUL0:
            begin
                mul_a      = ad_op;
                mul_b      = (cmd_reg == CMD_DIV) ? bn_op : bd_op;
                state_next = F_MUL1;
            end
            F_MUL1:
            begin
                den_next   = prod_reg;
                mul_a      = an_op;
                mul_b      = (cmd_reg == CMD_MUL) ? bn_op : bd_op;
                state_next = F_MUL2;
            end
            F_MUL2:
            begin
                num_next = NUM_W'(prod_reg);
                mul_a    = ad_op;
                mul_b    = bn_op;
                if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB)
                begin
                    state_next = F_SUM;
                end
                else
                begin
                    state_next = F_PUSH;
                end
            end
            F_SUM:
            begin
                if (cmd_reg == CMD_SUB)
                begin
                    num_next = num_reg - NUM_W'(prod_reg);
                end
                else
                begin
                    num_next = num_reg + NUM_W'(prod_reg);
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        prod_next = mul_a * mul_b;
    end

endmodule

/* hdl/rar_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// rar_queue
// Short FIFO of raw numerator/denominator pairs between front and back.
// ============================================================================
module rar_queue import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    localparam int DEN_W = 2 * OPERAND_WIDTH,
    localparam int NUM_W = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic signed [NUM_W-1:0] push_num,
    input  logic signed [DEN_W-1:0] push_den,
    input  logic                    pop,
    output logic signed [NUM_W-1:0] head_num,
    output logic signed [DEN_W-1:0] head_den,
    output q_stat_t                 q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic signed [NUM_W-1:0] num_mem [QUEUE_DEPTH];
    logic signed [DEN_W-1:0] den_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_num     = num_mem[rd_ptr_reg];
    assign head_den     = den_mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            num_mem[wr_ptr_reg] <= push_num;
            den_mem[wr_ptr_reg] <= push_den;
        end
    end

endmodule

/* hdl/rar_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// rar_back
// Binary gcd, bit-serial exact division and the result register.
// ============================================================================
`include "rational_arith_reduce_defines.svh"

module rar_back import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    localparam int DEN_W = 2 * OPERAND_WIDTH,
    localparam int NUM_W = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  q_stat_t                 q_stat,
    input  logic signed [NUM_W-1:0] head_num,
    input  logic signed [DEN_W-1:0] head_den,
    output logic                    pop,
    rar_out_if.source               result
);

    localparam int K_W = $clog2(NUM_W);

    back_state_t state_reg, state_next;

    // fraction being reduced; holds the signed result once done
    logic signed [NUM_W-1:0] val_num_reg, val_num_next;
    logic signed [DEN_W-1:0] val_den_reg, val_den_next;

    // gcd operands and common power of two
    logic [NUM_W-1:0] x_reg, x_next;
    logic [NUM_W-1:0] y_reg, y_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [NUM_W-1:0] g_reg, g_next;

    // divider lanes (numerator, denominator) sharing divisor g
    logic [NUM_W-1:0] qn_reg, qn_next, rn_reg, rn_next;
    logic [NUM_W-1:0] qd_reg, qd_next, rd_reg, rd_next;
    logic [K_W-1:0]   cnt_reg, cnt_next;

    logic                        out_valid_reg, out_valid_next;
    logic signed [RES_NUM_W-1:0] res_num_reg, res_num_next;
    logic signed [RES_DEN_W-1:0] res_den_reg, res_den_next;
    logic                        res_flag_reg, res_flag_next;

    logic [NUM_W-1:0] mag_num, mag_den;
    logic [NUM_W:0]   sh_n, sh_d, dif_n, dif_d;
    logic [NUM_W-1:0] x_minus_y, y_minus_x;
    logic             x_ge_y;
    logic             out_free;

    assign mag_num = val_num_reg[NUM_W-1] ? NUM_W'(-val_num_reg) : NUM_W'(val_num_reg);
    assign mag_den = val_den_reg[DEN_W-1] ? NUM_W'(DEN_W'(-val_den_reg))
                                          : NUM_W'(DEN_W'(val_den_reg));

    assign x_ge_y    = (x_reg >= y_reg);
    assign x_minus_y = x_reg - y_reg;
    assign y_minus_x = y_reg - x_reg;

    // restoring division step: shift in the next dividend bit, try subtracting
    assign sh_n  = {rn_reg, qn_reg[NUM_W-1]};
    assign sh_d  = {rd_reg, qd_reg[NUM_W-1]};
    assign dif_n = sh_n - {1'b0, g_reg};
    assign dif_d = sh_d - {1'b0, g_reg};

    assign out_free         = !out_valid_reg || result.ready;
    assign result.valid     = out_valid_reg;
    assign result.res_num   = res_num_reg;
    assign result.res_den   = res_den_reg;
    assign result.res_valid = res_flag_reg;

    always_comb
    begin
        state_next     = state_reg;
        val_num_next   = val_num_reg;
        val_den_next   = val_den_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        qn_next        = qn_reg;
        rn_next        = rn_reg;
        qd_next        = qd_reg;
        rd_next        = rd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        res_flag_next  = res_flag_reg;
        pop            = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop          = 1'b1;
                    val_num_next = head_num;
                    val_den_next = head_den;
                    state_next   = B_GCD;
                end
            end
            B_GCD:
            begin
                // first cycle loads magnitudes: k is zero and x, y come fresh
                if (cnt_reg == '0 && k_reg == '0 && x_reg == '0 && y_reg == '0)
                begin
                    x_next   = mag_num;
                    y_next   = mag_den;
                    cnt_next = K_W'(1);
                    if (mag_num == '0 && mag_den == '0)
                    begin
                        // both terms zero: no reduction
                        cnt_next   = '0;
                        state_next = B_HOLD;
                    end
                end
                else if (x_reg == '0 || y_reg == '0)
                begin
                    g_next     = (x_reg | y_reg) << k_reg;
                    qn_next    = mag_num;
                    qd_next    = mag_den;
                    rn_next    = '0;
                    rd_next    = '0;
                    cnt_next   = '0;
                    x_next     = '0;
                    y_next     = '0;
                    k_next     = '0;
                    state_next = B_DIV;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_ge_y)
                begin
                    x_next = x_minus_y;
                end
                else
                begin
                    y_next = y_minus_x;
                end
            end
            B_DIV:
            begin
                if (!dif_n[NUM_W])
                begin
                    rn_next = dif_n[NUM_W-1:0];
                    qn_next = {qn_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rn_next = sh_n[NUM_W-1:0];
                    qn_next = {qn_reg[NUM_W-2:0], 1'b0};
                end
                if (!dif_d[NUM_W])
                begin
                    rd_next = dif_d[NUM_W-1:0];
                    qd_next = {qd_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rd_next = sh_d[NUM_W-1:0];
                    qd_next = {qd_reg[NUM_W-2:0], 1'b0};
                end
                if (cnt_reg == K_W'(NUM_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = B_SIGN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_SIGN:
            begin
                val_num_next = val_num_reg[NUM_W-1] ? -qn_reg : qn_reg;
                val_den_next = val_den_reg[DEN_W-1] ? -DEN_W'(qd_reg) : DEN_W'(qd_reg);
                state_next   = B_HOLD;
            end
            B_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_num_next   = RES_NUM_W'(val_num_reg);
                    res_den_next   = RES_DEN_W'(val_den_reg);
                    res_flag_next  = (RES_DEN_W'(val_den_reg) != '0);
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_num_reg  <= val_num_next;
        val_den_reg  <= val_den_next;
        g_reg        <= g_next;
        qn_reg       <= qn_next;
        rn_reg       <= rn_next;
        qd_reg       <= qd_next;
        rd_reg       <= rd_next;
        res_num_reg  <= res_num_next;
        res_den_reg  <= res_den_next;
        res_flag_reg <= res_flag_next;
    end

    `RAR_ASSERT_IMPL(a_div_nonzero, state_reg == B_DIV, g_reg != '0, "gcd zero in division")
    `RAR_ASSERT_IMPL(a_rem_bound, state_reg == B_DIV, rn_reg < g_reg && rd_reg < g_reg, "remainder not below divisor")
    `RAR_ASSERT_IMPL(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
    `RAR_ASSERT_NEXT(a_hold_loads, state_reg == B_HOLD && out_free, out_valid_reg, "result not presented")

endmodule
